>>> hdl/lgtg_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the toroidal life grid. No dependencies.
`timescale 1ns / 1ps

package lgtg_pkg;

    localparam int GRID_COLUMNS = 40;
    localparam int GRID_ROWS    = 25;
    localparam int GRID_CELLS   = GRID_COLUMNS * GRID_ROWS;

    localparam int CMD_W   = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int POP_W   = 10;
    localparam int RADDR_W = $clog2(GRID_ROWS);
    localparam int CIDX_W  = $clog2(GRID_COLUMNS);

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

    typedef logic [3:0] op_t;

    localparam op_t OP_IDLE        = 4'd0;
    localparam op_t OP_ACCEPT      = 4'd1;
    localparam op_t OP_FETCH       = 4'd2;
    localparam op_t OP_GET_BIT     = 4'd3;
    localparam op_t OP_PUT_BIT     = 4'd4;
    localparam op_t OP_ADV_START   = 4'd5;
    localparam op_t OP_ADV_ROW0    = 4'd6;
    localparam op_t OP_ADV_CENTRE  = 4'd7;
    localparam op_t OP_ADV_FETCH   = 4'd8;
    localparam op_t OP_ADV_BELOW_M = 4'd9;
    localparam op_t OP_ADV_BELOW_F = 4'd10;
    localparam op_t OP_ADV_CELL    = 4'd11;
    localparam op_t OP_ADV_WB      = 4'd12;
    localparam op_t OP_ADV_DONE    = 4'd13;
    localparam op_t OP_RESPOND     = 4'd14;

    typedef struct packed {
        op_t                op;
        logic [RADDR_W-1:0] addr;
        logic [CIDX_W-1:0]  col;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             out_busy;
    } dp_status_t;

endpackage

>>> hdl/lgtg_datapath.sv
// Datapath of the toroidal life grid: row memory, row windows, neighbour count,
// population counter and result register. Depends on lgtg_pkg.
`timescale 1ns / 1ps

module lgtg_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lgtg_pkg::CMD_W-1:0]   s_cmd,
    input  logic [lgtg_pkg::ROW_W-1:0]   s_row,
    input  logic [lgtg_pkg::COL_W-1:0]   s_column,
    input  logic                         s_cell_value,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic                         m_read_value,
    output logic [lgtg_pkg::POP_W-1:0]   m_population,
    input  lgtg_pkg::dp_cmd_t            ctl,
    output lgtg_pkg::dp_status_t         st
);

    localparam int C = lgtg_pkg::GRID_COLUMNS;
    localparam int R = lgtg_pkg::GRID_ROWS;

    logic [lgtg_pkg::CMD_W-1:0]   cmd_reg;
    logic [lgtg_pkg::ROW_W-1:0]   row_reg;
    logic [lgtg_pkg::COL_W-1:0]   col_reg;
    logic                         val_reg;
    logic                         rv_reg;
    logic [lgtg_pkg::POP_W-1:0]   total_reg;
    logic [lgtg_pkg::POP_W-1:0]   count_reg;

    logic [C-1:0] row_mem [R];
    logic [R-1:0] row_vld_reg;
    logic [C-1:0] rd_raw_reg;
    logic         rd_vld_reg;
    logic [C-1:0] rd_data;

    logic [C-1:0] above_reg;
    logic [C-1:0] centre_reg;
    logic [C-1:0] below_reg;
    logic [C-1:0] first_reg;
    logic [C-1:0] next_row_reg;

    logic                         m_valid_reg;
    logic                         m_rv_reg;
    logic [lgtg_pkg::POP_W-1:0]   m_pop_reg;

    logic [lgtg_pkg::RADDR_W-1:0] row_idx;
    logic [lgtg_pkg::CIDX_W-1:0]  col_idx;
    logic                         rd_en;
    logic [lgtg_pkg::RADDR_W-1:0] rd_addr;
    logic                         wr_en;
    logic [lgtg_pkg::RADDR_W-1:0] wr_addr;
    logic [C-1:0]                 wr_data;
    logic                         differs;

    logic [lgtg_pkg::CIDX_W-1:0]  cl;
    logic [lgtg_pkg::CIDX_W-1:0]  cc;
    logic [lgtg_pkg::CIDX_W-1:0]  cr;
    logic [3:0]                   nbr;
    logic                         alive;

    assign row_idx = row_reg[lgtg_pkg::RADDR_W-1:0];
    assign col_idx = col_reg[lgtg_pkg::CIDX_W-1:0];
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;
    assign differs = (rd_data[col_idx] != val_reg);

    assign st.cmd      = cmd_reg;
    assign st.in_range = (row_reg < R) && (col_reg < C);
    assign st.out_busy = m_valid_reg && !m_ready;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ctl.addr;
        wr_en   = 1'b0;
        wr_addr = ctl.addr;
        wr_data = next_row_reg;
        case (ctl.op)
            lgtg_pkg::OP_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = row_idx;
            end
            lgtg_pkg::OP_ADV_START, lgtg_pkg::OP_ADV_ROW0, lgtg_pkg::OP_ADV_FETCH: begin
                rd_en = 1'b1;
            end
            lgtg_pkg::OP_PUT_BIT: begin
                wr_en            = differs;
                wr_addr          = row_idx;
                wr_data          = rd_data;
                wr_data[col_idx] = val_reg;
            end
            lgtg_pkg::OP_ADV_WB: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        cc  = ctl.col;
        cl  = (cc == '0) ? lgtg_pkg::CIDX_W'(C - 1) : cc - 1'b1;
        cr  = (cc == lgtg_pkg::CIDX_W'(C - 1)) ? '0 : cc + 1'b1;
        nbr = {3'b000, above_reg[cl]}  + {3'b000, above_reg[cc]}  + {3'b000, above_reg[cr]}
            + {3'b000, centre_reg[cl]} + {3'b000, centre_reg[cr]}
            + {3'b000, below_reg[cl]}  + {3'b000, below_reg[cc]}  + {3'b000, below_reg[cr]};
        alive = (nbr == 4'd3) || ((nbr == 4'd2) && centre_reg[cc]);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg <= row_mem[rd_addr];
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        case (ctl.op)
            lgtg_pkg::OP_ACCEPT: begin
                cmd_reg <= s_cmd;
                row_reg <= s_row;
                col_reg <= s_column;
                val_reg <= s_cell_value;
                rv_reg  <= 1'b0;
            end
            lgtg_pkg::OP_GET_BIT: begin
                rv_reg <= rd_data[col_idx];
            end
            lgtg_pkg::OP_ADV_START: begin
                count_reg <= '0;
            end
            lgtg_pkg::OP_ADV_ROW0: begin
                above_reg <= rd_data;
            end
            lgtg_pkg::OP_ADV_CENTRE: begin
                centre_reg <= rd_data;
                first_reg  <= rd_data;
            end
            lgtg_pkg::OP_ADV_BELOW_M: begin
                below_reg <= rd_data;
            end
            lgtg_pkg::OP_ADV_BELOW_F: begin
                below_reg <= first_reg;
            end
            lgtg_pkg::OP_ADV_CELL: begin
                next_row_reg[cc] <= alive;
                count_reg        <= count_reg + {{(lgtg_pkg::POP_W-1){1'b0}}, alive};
            end
            lgtg_pkg::OP_ADV_WB: begin
                above_reg  <= centre_reg;
                centre_reg <= below_reg;
            end
            lgtg_pkg::OP_RESPOND: begin
                m_rv_reg  <= rv_reg;
                m_pop_reg <= total_reg;
            end
            default: begin
                rv_reg <= rv_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.op == lgtg_pkg::OP_PUT_BIT && differs) begin
                total_reg <= val_reg ? total_reg + 1'b1 : total_reg - 1'b1;
            end else if (ctl.op == lgtg_pkg::OP_ADV_DONE) begin
                total_reg <= count_reg;
            end
            if (ctl.op == lgtg_pkg::OP_RESPOND) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_rv_reg;
    assign m_population = m_pop_reg;

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= lgtg_pkg::GRID_CELLS)
        else $error("population beyond grid size");

    a_respond_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.op == lgtg_pkg::OP_RESPOND |=> m_valid_reg)
        else $error("result not presented after load");
`endif

endmodule

>>> hdl/lgtg_ctrl.sv
// Controller of the toroidal life grid: sequences cell access and the
// row-by-row generation scan. Depends on lgtg_pkg.
`timescale 1ns / 1ps

module lgtg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lgtg_pkg::dp_status_t  st,
    output lgtg_pkg::dp_cmd_t     ctl
);

    localparam int C = lgtg_pkg::GRID_COLUMNS;
    localparam int R = lgtg_pkg::GRID_ROWS;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_USE        = 4'd2;
    localparam logic [3:0] S_ADV_ROW0   = 4'd3;
    localparam logic [3:0] S_ADV_CENTRE = 4'd4;
    localparam logic [3:0] S_ADV_FETCH  = 4'd5;
    localparam logic [3:0] S_ADV_BELOW  = 4'd6;
    localparam logic [3:0] S_ADV_CELL   = 4'd7;
    localparam logic [3:0] S_ADV_WB     = 4'd8;
    localparam logic [3:0] S_ADV_DONE   = 4'd9;
    localparam logic [3:0] S_RESP       = 4'd10;

    localparam logic [lgtg_pkg::RADDR_W-1:0] LAST_ROW = lgtg_pkg::RADDR_W'(R - 1);
    localparam logic [lgtg_pkg::CIDX_W-1:0]  LAST_COL = lgtg_pkg::CIDX_W'(C - 1);

    logic [3:0]                   state_reg, state_next;
    logic [lgtg_pkg::RADDR_W-1:0] row_reg, row_next;
    logic [lgtg_pkg::CIDX_W-1:0]  col_reg, col_next;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ctl.op     = lgtg_pkg::OP_IDLE;
        ctl.addr   = row_reg;
        ctl.col    = col_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.op     = lgtg_pkg::OP_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.cmd == lgtg_pkg::CMD_WRITE || st.cmd == lgtg_pkg::CMD_READ) begin
                    if (st.in_range) begin
                        ctl.op     = lgtg_pkg::OP_FETCH;
                        state_next = S_USE;
                    end else begin
                        state_next = S_RESP;
                    end
                end else if (st.cmd == lgtg_pkg::CMD_ADVANCE) begin
                    ctl.op     = lgtg_pkg::OP_ADV_START;
                    ctl.addr   = LAST_ROW;
                    state_next = S_ADV_ROW0;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_USE: begin
                ctl.op     = (st.cmd == lgtg_pkg::CMD_READ) ? lgtg_pkg::OP_GET_BIT
                                                             : lgtg_pkg::OP_PUT_BIT;
                state_next = S_RESP;
            end
            S_ADV_ROW0: begin
                ctl.op     = lgtg_pkg::OP_ADV_ROW0;
                ctl.addr   = '0;
                state_next = S_ADV_CENTRE;
            end
            S_ADV_CENTRE: begin
                ctl.op     = lgtg_pkg::OP_ADV_CENTRE;
                row_next   = '0;
                state_next = S_ADV_FETCH;
            end
            S_ADV_FETCH: begin
                col_next = '0;
                if (row_reg == LAST_ROW) begin
                    ctl.op     = lgtg_pkg::OP_ADV_BELOW_F;
                    state_next = S_ADV_CELL;
                end else begin
                    ctl.op     = lgtg_pkg::OP_ADV_FETCH;
                    ctl.addr   = row_reg + 1'b1;
                    state_next = S_ADV_BELOW;
                end
            end
            S_ADV_BELOW: begin
                ctl.op     = lgtg_pkg::OP_ADV_BELOW_M;
                state_next = S_ADV_CELL;
            end
            S_ADV_CELL: begin
                ctl.op = lgtg_pkg::OP_ADV_CELL;
                if (col_reg == LAST_COL) begin
                    state_next = S_ADV_WB;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_ADV_WB: begin
                ctl.op = lgtg_pkg::OP_ADV_WB;
                if (row_reg == LAST_ROW) begin
                    state_next = S_ADV_DONE;
                end else begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_ADV_FETCH;
                end
            end
            S_ADV_DONE: begin
                ctl.op     = lgtg_pkg::OP_ADV_DONE;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!st.out_busy) begin
                    ctl.op     = lgtg_pkg::OP_RESPOND;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_col_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ADV_CELL |-> col_reg <= LAST_COL)
        else $error("scan column outside grid");

    a_last_row_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADV_WB && row_reg == LAST_ROW) |=> state_reg == S_ADV_DONE)
        else $error("scan did not finish after last row");

    a_resp_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && !st.out_busy) |=> state_reg == S_IDLE)
        else $error("result load did not free the input");
`endif

endmodule

>>> hdl/life_generation_toroidal_grid.sv
// An in-range write or read passes decode, row fetch and bit access before its result is
// registered; out-of-range access and the unused command go from decode to the result.
// Advance scans one cell per cycle through the neighbour count, plus a row fetch and
// write-back per row. One item at a time: the next transfer is taken the cycle after the
// result is registered.
// Reset: synchronous, active low; per-row valid flags make the grid read dead.
`timescale 1ns / 1ps

module life_generation_toroidal_grid (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lgtg_pkg::CMD_W-1:0]   s_cmd,
    input  logic [lgtg_pkg::ROW_W-1:0]   s_row,
    input  logic [lgtg_pkg::COL_W-1:0]   s_column,
    input  logic                         s_cell_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_read_value,
    output logic [lgtg_pkg::POP_W-1:0]   m_population
);

    lgtg_pkg::dp_cmd_t    ctl;
    lgtg_pkg::dp_status_t st;

    lgtg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    lgtg_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_cell_value (s_cell_value),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_read_value (m_read_value),
        .m_population (m_population),
        .ctl          (ctl),
        .st           (st)
    );

endmodule

>>> tb/tb_life_generation_toroidal_grid.sv
// Self-checking testbench for the toroidal life grid: random and directed cell
// writes, reads and generation steps, checked against an in-bench grid model.
// Depends on lgtg_pkg and life_generation_toroidal_grid.
`timescale 1ns / 1ps

module tb_life_generation_toroidal_grid;

    localparam logic [lgtg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int TARGET_ITEMS = 600;
    localparam int POP_MAX      = (1 << lgtg_pkg::POP_W) - 1;

    typedef struct packed {
        logic                       read_value;
        logic [lgtg_pkg::POP_W-1:0] population;
    } life_result_t;

    class life_scoreboard;
        bit           cells [lgtg_pkg::GRID_ROWS][lgtg_pkg::GRID_COLUMNS];
        int           live_cells;
        int           mismatches;
        life_result_t expected_q[$];

        function new();
            foreach (cells[r, c]) cells[r][c] = 1'b0;
            live_cells = 0;
            mismatches = 0;
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
        endfunction

        function void step_generation();
            bit old_cells [lgtg_pkg::GRID_ROWS][lgtg_pkg::GRID_COLUMNS];
            int neighbours;
            int rr;
            int cc;
            old_cells  = cells;
            live_cells = 0;
            for (int r = 0; r < lgtg_pkg::GRID_ROWS; r++) begin
                for (int c = 0; c < lgtg_pkg::GRID_COLUMNS; c++) begin
                    neighbours = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                rr = (r + dr + lgtg_pkg::GRID_ROWS) % lgtg_pkg::GRID_ROWS;
                                cc = (c + dc + lgtg_pkg::GRID_COLUMNS) % lgtg_pkg::GRID_COLUMNS;
                                neighbours += old_cells[rr][cc];
                            end
                        end
                    end
                    cells[r][c] = (neighbours == 3) || (neighbours == 2 && old_cells[r][c]);
                    live_cells += cells[r][c];
                end
            end
        endfunction

        function void note_input(logic [lgtg_pkg::CMD_W-1:0] cmd,
                                 logic [lgtg_pkg::ROW_W-1:0] row,
                                 logic [lgtg_pkg::COL_W-1:0] col, logic value);
            life_result_t res;
            bit           in_grid;
            in_grid        = (row < lgtg_pkg::GRID_ROWS) && (col < lgtg_pkg::GRID_COLUMNS);
            res.read_value = 1'b0;
            case (cmd)
                lgtg_pkg::CMD_WRITE: begin
                    if (in_grid && cells[row][col] != value) begin
                        cells[row][col] = value;
                        live_cells += value ? 1 : -1;
                    end
                end
                lgtg_pkg::CMD_READ: begin
                    if (in_grid) res.read_value = cells[row][col];
                end
                lgtg_pkg::CMD_ADVANCE: begin
                    step_generation();
                end
                default: begin
                end
            endcase
            res.population = (live_cells > POP_MAX) ? POP_MAX[lgtg_pkg::POP_W-1:0]
                                                     : live_cells[lgtg_pkg::POP_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic read_value, logic [lgtg_pkg::POP_W-1:0] population);
            life_result_t want;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("result transfer with nothing outstanding (rv %0b pop %0d)",
                                       read_value, population));
                return;
            end
            want = expected_q.pop_front();
            if (read_value !== want.read_value || population !== want.population)
                log_mismatch($sformatf("read_value exp %0b got %0b, population exp %0d got %0d",
                                       want.read_value, read_value,
                                       want.population, population));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic [lgtg_pkg::CMD_W-1:0] s_cmd        = '0;
    logic [lgtg_pkg::ROW_W-1:0] s_row        = '0;
    logic [lgtg_pkg::COL_W-1:0] s_column     = '0;
    logic                       s_cell_value = 1'b0;
    logic                       m_ready      = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_read_value;
    logic [lgtg_pkg::POP_W-1:0] m_population;

    life_scoreboard grid_sb;
    bit             steady          = 1'b0;
    int             cycle_count     = 0;
    int             effective_items = 0;

    life_generation_toroidal_grid dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_population (m_population)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) grid_sb.check_result(m_read_value, m_population);
    end

    task automatic send_item(input logic [lgtg_pkg::CMD_W-1:0] cmd, input int row,
                             input int col, input logic value);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 33) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_row        <= row[lgtg_pkg::ROW_W-1:0];
        s_column     <= col[lgtg_pkg::COL_W-1:0];
        s_cell_value <= value;
        do @(posedge aclk); while (!s_ready);
        grid_sb.note_input(s_cmd, s_row, s_column, s_cell_value);
        if (!(cmd == CMD_UNUSED ||
              (cmd == lgtg_pkg::CMD_WRITE &&
               (row >= lgtg_pkg::GRID_ROWS || col >= lgtg_pkg::GRID_COLUMNS))))
            effective_items++;
    endtask

    // seed a small pattern in a window that often straddles an edge, then evolve it
    task automatic pattern_burst();
        int base_r;
        int base_c;
        base_r = $urandom_range(0, 1) ? lgtg_pkg::GRID_ROWS - 2
                                      : $urandom_range(0, lgtg_pkg::GRID_ROWS - 1);
        base_c = $urandom_range(0, 1) ? lgtg_pkg::GRID_COLUMNS - 2
                                      : $urandom_range(0, lgtg_pkg::GRID_COLUMNS - 1);
        repeat ($urandom_range(3, 12))
            send_item(lgtg_pkg::CMD_WRITE, (base_r + $urandom_range(0, 4)) % lgtg_pkg::GRID_ROWS,
                      (base_c + $urandom_range(0, 4)) % lgtg_pkg::GRID_COLUMNS,
                      $urandom_range(0, 9) < 8);
        repeat ($urandom_range(1, 3)) begin
            send_item(lgtg_pkg::CMD_ADVANCE, $urandom_range(0, 31), $urandom_range(0, 63),
                      1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
                send_item(lgtg_pkg::CMD_READ,
                          (base_r + $urandom_range(0, 6)) % lgtg_pkg::GRID_ROWS,
                          (base_c + $urandom_range(0, 6)) % lgtg_pkg::GRID_COLUMNS,
                          1'($urandom_range(0, 1)));
        end
    endtask

    task automatic scatter_burst();
        repeat (8)
            send_item($urandom_range(0, 1) ? lgtg_pkg::CMD_WRITE : lgtg_pkg::CMD_READ,
                      $urandom_range(0, lgtg_pkg::GRID_ROWS - 1),
                      $urandom_range(0, lgtg_pkg::GRID_COLUMNS - 1),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic noise_burst();
        repeat (4)
            send_item(lgtg_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                      $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int pick;
        grid_sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(lgtg_pkg::CMD_READ,    0, 0, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   0, 0, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   0, lgtg_pkg::GRID_COLUMNS - 1, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   lgtg_pkg::GRID_ROWS - 1, 0, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   lgtg_pkg::GRID_ROWS - 1,
                  lgtg_pkg::GRID_COLUMNS - 1, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   lgtg_pkg::GRID_ROWS - 1,
                  lgtg_pkg::GRID_COLUMNS - 1, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   5, 5, 1'b0);
        send_item(lgtg_pkg::CMD_WRITE,   31, 63, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   lgtg_pkg::GRID_ROWS, 0, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   0, lgtg_pkg::GRID_COLUMNS, 1'b1);
        send_item(lgtg_pkg::CMD_READ,    31, 63, 1'b0);
        send_item(lgtg_pkg::CMD_READ,    lgtg_pkg::GRID_ROWS - 1,
                  lgtg_pkg::GRID_COLUMNS - 1, 1'b0);
        send_item(CMD_UNUSED,            31, 63, 1'b1);
        send_item(lgtg_pkg::CMD_ADVANCE, 0, 0, 1'b0);
        send_item(lgtg_pkg::CMD_READ,    0, lgtg_pkg::GRID_COLUMNS - 1, 1'b0);
        send_item(lgtg_pkg::CMD_WRITE,   12, lgtg_pkg::GRID_COLUMNS - 1, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   12, 0, 1'b1);
        send_item(lgtg_pkg::CMD_WRITE,   12, 1, 1'b1);
        send_item(lgtg_pkg::CMD_ADVANCE, 31, 63, 1'b1);
        send_item(lgtg_pkg::CMD_READ,    11, 0, 1'b1);
        send_item(lgtg_pkg::CMD_READ,    12, lgtg_pkg::GRID_COLUMNS - 1, 1'b0);
        send_item(lgtg_pkg::CMD_WRITE,   0, 0, 1'b0);
        send_item(lgtg_pkg::CMD_ADVANCE, 16, 32, 1'b0);

        while (effective_items < TARGET_ITEMS) begin
            steady = (effective_items >= 250 && effective_items < 350);
            pick   = $urandom_range(0, 99);
            if (pick < 70) pattern_burst();
            else if (pick < 90) scatter_burst();
            else noise_burst();
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (grid_sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (grid_sb.mismatches == 0 && grid_sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/lgtg_pkg.sv
hdl/lgtg_datapath.sv
hdl/lgtg_ctrl.sv
hdl/life_generation_toroidal_grid.sv
tb/tb_life_generation_toroidal_grid.sv
